[hdl/fpa_pkg.sv]
// ---------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the fixed partition allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int NUM_PARTS = 32;
  localparam int SIZE_W    = 16;
  localparam int REQ_W     = 16;
  localparam int PIDX_W    = 5;
  localparam int OIDX_W    = 5;
  localparam int BC_W      = 6;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;

  localparam int IDX_W  = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int CNT_W  = $clog2(NUM_PARTS + 1);
  localparam int NEED_W = (SIZE_W > REQ_W) ? SIZE_W : REQ_W;
  localparam int ZW     = ((PIDX_W > IDX_W) ? PIDX_W : IDX_W) + 1;
  localparam int LIM_W  = (BC_W > CNT_W) ? BC_W : CNT_W;

  // request types
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_ALLOC   = 2'd1;
  localparam logic [1:0] REQ_RESTORE = 2'd2;

  // response status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_GRANT = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;

  // fit policies (anything else is first fit)
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [PIDX_W-1:0] part_index;
    logic [REQ_W-1:0]  req_size;
  } fpa_cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OIDX_W-1:0] granted_index;
  } fpa_rsp_t;

  // table update broadcast to every cell
  typedef struct packed {
    logic              load;
    logic              clear;
    logic              grant;
    logic [IDX_W-1:0]  wr_idx;
    logic [SIZE_W-1:0] wr_size;
    logic [IDX_W-1:0]  grant_idx;
  } fpa_ctl_t;

  // search terms broadcast to every cell
  typedef struct packed {
    logic [NEED_W-1:0] need;
    logic [MODE_W-1:0] mode;
    logic [LIM_W-1:0]  limit;
  } fpa_scan_t;

  // best-so-far record travelling down the chain
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
  } fpa_cand_t;

endpackage

`default_nettype wire

[hdl/fpa_cell.sv]
// ---------------------------------------------------------------------------
// fpa_cell
// One partition entry: size and used mark, plus one step of the fit search.
// ---------------------------------------------------------------------------
`default_nettype none

module fpa_cell
  import fpa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire fpa_ctl_t         ctl,
  input  wire fpa_scan_t        scan,
  input  wire fpa_cand_t        cand_in,
  output fpa_cand_t             cand_out,
  output logic                  used
);

  logic [SIZE_W-1:0] size;
  logic              eligible;
  logic              take;
  fpa_cand_t         cand_next;

  always_ff @(posedge clk) begin
    if (ctl.load && ctl.wr_idx == cell_idx) begin
      size <= ctl.wr_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctl.clear) begin
      used <= 1'b0;
    end else if (ctl.load && ctl.wr_idx == cell_idx) begin
      used <= 1'b0;
    end else if (ctl.grant && ctl.grant_idx == cell_idx) begin
      used <= 1'b1;
    end
  end

  always_comb begin
    eligible = (LIM_W'(cell_idx) < scan.limit) && !used &&
               (NEED_W'(size) >= scan.need);
    take = eligible &&
           (!cand_in.found ||
            (scan.mode == FIT_BEST  && size < cand_in.size) ||
            (scan.mode == FIT_WORST && size > cand_in.size));
    cand_next = cand_in;
    if (take) begin
      cand_next.found = 1'b1;
      cand_next.idx   = cell_idx;
      cand_next.size  = size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.found <= 1'b0;
    end else begin
      cand_out.found <= cand_next.found;
    end
    cand_out.idx  <= cand_next.idx;
    cand_out.size <= cand_next.size;
  end

endmodule

`default_nettype wire

[hdl/fixed_partition_allocator_top.sv]
// ---------------------------------------------------------------------------
// fixed_partition_allocator_top
// Fixed partition table with first, best and worst fit allocation.
// ---------------------------------------------------------------------------
//
//  channel  signals                         word
//  -------  ------------------------------  ---------------------------------
//  cmd      cmd_valid / cmd_ready / cmd     req_type, part_index, req_size
//  rsp      rsp_valid / rsp_ready / rsp     status, granted_index
//  cfg      cfg_valid / cfg_ready / index   cfg_data into fit_mode, block_count
//
//  Load and restore words: the response is registered when the word is taken.
//  Allocate: the response waits for the candidate record walking the row
//    of cells one cell per clock.
//  Reset: used marks cleared, fit_mode first fit, block_count 32; sizes
//    stay undefined until loaded.
//  A stalled rsp holds the finished allocate in the scan state; cmd is taken
//    only when idle and the response register is free or draining.
//  cfg_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module fixed_partition_allocator_top
  import fpa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire fpa_cmd_t             cmd,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output fpa_rsp_t                  rsp,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    IDLE = 2'b01,
    SCAN = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt;
  logic [NEED_W-1:0] need;
  logic [MODE_W-1:0] fit_mode;
  logic [BC_W-1:0]   block_count;
  logic [LIM_W-1:0]  bc_ext;
  logic [ZW-1:0]     pidx_ext;
  logic [ZW-1:0]     pick_ext;

  logic      cmd_fire, rsp_free, scan_done;
  fpa_ctl_t  ctl;
  fpa_scan_t scan;
  fpa_cand_t chain [NUM_PARTS+1];
  logic [NUM_PARTS-1:0] used_vec;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode    <= FIT_FIRST;
      block_count <= BC_W'(32);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIT_MODE:    fit_mode    <= cfg_data[MODE_W-1:0];
        CFG_BLOCK_COUNT: block_count <= cfg_data[BC_W-1:0];
        default: ;
      endcase
    end
  end

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign cmd_ready = (state == IDLE) && rsp_free;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign scan_done = (state == SCAN) && (cnt == CNT_W'(NUM_PARTS)) && rsp_free;

  // load index range check, widened so NUM_PARTS itself fits
  assign pidx_ext = ZW'(cmd.part_index);
  assign pick_ext = ZW'(chain[NUM_PARTS].idx);

  // block_count widened; the scan limit below saturates it at the table depth
  assign bc_ext = LIM_W'(block_count);

  always_comb begin
    ctl.load      = cmd_fire && cmd.req_type == REQ_LOAD &&
                    pidx_ext < ZW'(NUM_PARTS);
    ctl.clear     = cmd_fire && cmd.req_type == REQ_RESTORE;
    ctl.grant     = scan_done && chain[NUM_PARTS].found;
    ctl.wr_idx    = pidx_ext[IDX_W-1:0];
    ctl.wr_size   = cmd.req_size[SIZE_W-1:0];
    ctl.grant_idx = chain[NUM_PARTS].idx;
    scan.need     = need;
    scan.mode     = fit_mode;
    scan.limit    = (bc_ext > LIM_W'(NUM_PARTS)) ? LIM_W'(NUM_PARTS) : bc_ext;
  end

  // chain head always injects an empty record; once it has walked every cell
  // with stable table and terms the tail holds the chosen partition
  always_comb begin
    chain[0] = '0;
  end

  for (genvar k = 0; k < NUM_PARTS; k++) begin : g_cell
    fpa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(k)),
      .ctl      (ctl),
      .scan     (scan),
      .cand_in  (chain[k]),
      .cand_out (chain[k+1]),
      .used     (used_vec[k])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      IDLE: if (cmd_fire && cmd.req_type == REQ_ALLOC) state_next = SCAN;
      SCAN: if (scan_done) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (cmd_fire) begin
        cnt <= '0;
      end else if (state == SCAN && cnt != CNT_W'(NUM_PARTS)) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      need <= NEED_W'(cmd.req_size);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (scan_done || (cmd_fire && cmd.req_type != REQ_ALLOC)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      if (chain[NUM_PARTS].found) begin
        rsp.status        <= ST_GRANT;
        rsp.granted_index <= pick_ext[OIDX_W-1:0];
      end else begin
        rsp.status        <= ST_NOFIT;
        rsp.granted_index <= '0;
      end
    end else if (cmd_fire) begin
      rsp.status        <= ST_DONE;
      rsp.granted_index <= '0;
    end
  end

  // ---- checks ----
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(NUM_PARTS))
    else $error("scan counter overran");

  a_cmd_progress: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> (rsp_valid || state == SCAN))
    else $error("accepted word produced no response or scan");

  a_grant_marks: assert property (@(posedge clk) disable iff (rst)
    ctl.grant |=> used_vec[$past(chain[NUM_PARTS].idx)])
    else $error("granted partition not marked used");

  a_nofit_index: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_GRANT) |-> rsp.granted_index == '0)
    else $error("index set without a grant");

endmodule

`default_nettype wire

[tb/sv/fixed_partition_allocator_top_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fixed_partition_allocator_top_test
// Self-checking bench for the fixed partition allocator: a queue-fed command
// driver, a response monitor and a behavioural copy of the partition table
// that works out the status and granted index of every accepted word.
// ---------------------------------------------------------------------------

module fixed_partition_allocator_top_test;
  import fpa_pkg::*;

  // Codes the package does not name: spare register slots, the ignored
  // request type and the fourth policy value (behaves as first fit).
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [1:0]           REQ_NOP     = 2'd3;
  localparam logic [MODE_W-1:0]    FIT_ALT     = 2'd3;

  localparam int RANDOM_WORDS = 2000;

  // -------------------------------------------------------------------------
  // Clock, reset and DUT connections; every input is known from time zero.
  // -------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_ready;
  fpa_cmd_t             cmd       = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  fpa_rsp_t             rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fixed_partition_allocator_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // -------------------------------------------------------------------------
  // Shadow of the partition table, updated in handshake order at the rising
  // edge so that config writes and command words land in the same sequence
  // the DUT sees them.
  // -------------------------------------------------------------------------
  logic [SIZE_W-1:0] shadow_size [NUM_PARTS];
  logic              shadow_used [NUM_PARTS];
  logic [MODE_W-1:0] shadow_mode;
  logic [BC_W-1:0]   shadow_count;

  fpa_cmd_t cmd_backlog [$];   // words waiting for the driver
  fpa_rsp_t due_rsp [$];       // responses owed by the DUT, oldest first

  int queued_count   = 0;      // words put in the backlog
  int taken_count    = 0;      // words accepted by the DUT
  int rsp_count      = 0;
  int mismatch_count = 0;

  logic cmd_took = 1'b0;       // handshake seen at the last rising edge
  logic cfg_took = 1'b0;

  // idling control: 0 means no idling, otherwise roughly 1 in idle_odds
  int   idle_odds = 4;
  logic quiet     = 1'b0;      // final stretch, both sides run flat out
  int   cmd_gap   = 0;
  int   rsp_stall = 0;

  // generator-side view of loaded sizes, only used to aim requests
  logic [SIZE_W-1:0] staged_size [NUM_PARTS];
  logic              narrow_sizes = 1'b0;

  // Scan 0 .. count-1 (saturated) for a free partition big enough; first fit
  // keeps the first hit, best/worst replace only on a strictly better size so
  // ties stay on the lowest index.
  function automatic fpa_rsp_t alloc_outcome(fpa_cmd_t c);
    fpa_rsp_t   r;
    int         span;
    int         pick;
    logic       found;
    r     = '0;
    found = 1'b0;
    pick  = 0;
    span  = (shadow_count > NUM_PARTS) ? NUM_PARTS : int'(shadow_count);
    r.status = ST_DONE;
    case (c.req_type)
      REQ_LOAD: begin
        shadow_size[c.part_index] = c.req_size[SIZE_W-1:0];
        shadow_used[c.part_index] = 1'b0;
      end
      REQ_ALLOC: begin
        for (int k = 0; k < span; k++) begin
          if (!shadow_used[k] && shadow_size[k] >= c.req_size) begin
            if (!found) begin
              found = 1'b1;
              pick  = k;
            end else if (shadow_mode == FIT_BEST && shadow_size[k] < shadow_size[pick]) begin
              pick = k;
            end else if (shadow_mode == FIT_WORST && shadow_size[k] > shadow_size[pick]) begin
              pick = k;
            end
          end
        end
        if (found) begin
          shadow_used[pick] = 1'b1;
          r.status          = ST_GRANT;
          r.granted_index   = pick[OIDX_W-1:0];
        end else begin
          r.status = ST_NOFIT;
        end
      end
      REQ_RESTORE: begin
        for (int k = 0; k < NUM_PARTS; k++) shadow_used[k] = 1'b0;
      end
      default: ;  // ignored word, plain done
    endcase
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Monitor: sample at the rising edge, before the DUT's registers move.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    fpa_rsp_t want;
    cmd_took <= cmd_valid && cmd_ready && !rst;
    cfg_took <= cfg_valid && cfg_ready && !rst;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIT_MODE)
          shadow_mode = cfg_data[MODE_W-1:0];
        else if (cfg_index == CFG_BLOCK_COUNT)
          shadow_count = cfg_data[BC_W-1:0];
      end
      if (cmd_valid && cmd_ready) begin
        due_rsp.push_back(alloc_outcome(cmd));
        taken_count++;
      end
      if (rsp_valid && rsp_ready) begin
        rsp_count++;
        if (due_rsp.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("rsp %0d: unexpected word, status %0d index %0d",
                     rsp_count, rsp.status, rsp.granted_index);
        end else begin
          want = due_rsp.pop_front();
          if (rsp.status !== want.status || rsp.granted_index !== want.granted_index) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("rsp %0d: expected status %0d index %0d, got status %0d index %0d",
                       rsp_count, want.status, want.granted_index,
                       rsp.status, rsp.granted_index);
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Command driver: falling edge, holds a word until the monitor saw it go.
  // Random gaps are scheduled after a word is presented.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_took) begin
      if (cmd_gap > 0) begin
        cmd_gap--;
        cmd_valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        cmd       <= cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
        if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
          cmd_gap = $urandom_range(1, 5);
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // random response back-pressure in bursts
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
        rsp_stall = $urandom_range(1, 5);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic push_cmd(logic [1:0] kind, logic [PIDX_W-1:0] idx, logic [REQ_W-1:0] sz);
    fpa_cmd_t w;
    w.req_type   = kind;
    w.part_index = idx;
    w.req_size   = sz;
    if (kind == REQ_LOAD) staged_size[idx] = sz[SIZE_W-1:0];
    cmd_backlog.push_back(w);
    queued_count++;
  endtask

  // nothing in flight: every queued word taken and answered
  task automatic wait_drained();
    do @(negedge clk); while (taken_count != queued_count || due_rsp.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [REQ_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return narrow_sizes ? REQ_W'($urandom_range(0, 15))
                                   : REQ_W'($urandom_range(0, 65535));
      default: return REQ_W'($urandom_range(1, 300));
    endcase
  endfunction

  // request aimed at a loaded size: exact, a little under, or one over
  function automatic logic [REQ_W-1:0] aimed_request();
    logic [SIZE_W-1:0] s;
    logic [SIZE_W-1:0] d;
    s = staged_size[$urandom_range(0, NUM_PARTS - 1)];
    d = SIZE_W'($urandom_range(0, 3));
    if (d == SIZE_W'(3)) return (s == '1) ? s : s + 1'b1;
    return (s > d) ? s - d : '0;
  endfunction

  function automatic logic [PIDX_W-1:0] any_idx();
    return PIDX_W'($urandom_range(0, NUM_PARTS - 1));
  endfunction

  task automatic queue_phase(int n);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        push_cmd(REQ_ALLOC, any_idx(), aimed_request());
      end else if (roll < 55) begin
        push_cmd(REQ_ALLOC, any_idx(), pick_size());
      end else if (roll < 75) begin
        push_cmd(REQ_LOAD, any_idx(), pick_size());
      end else if (roll < 83) begin
        push_cmd(REQ_RESTORE, any_idx(), pick_size());
      end else if (roll < 88) begin
        push_cmd(REQ_NOP, any_idx(), pick_size());
      end else begin
        // run the table dry, then free it again
        repeat ($urandom_range(4, 12)) push_cmd(REQ_ALLOC, any_idx(), aimed_request());
        push_cmd(REQ_RESTORE, any_idx(), pick_size());
      end
    end
  endtask

  task automatic pick_settings();
    int               roll;
    logic [BC_W-1:0]  cnt;
    roll = $urandom_range(0, 9);
    if (roll == 0)      cnt = '0;
    else if (roll == 1) cnt = BC_W'($urandom_range(NUM_PARTS + 1, 63));
    else if (roll < 4)  cnt = BC_W'(NUM_PARTS);
    else                cnt = BC_W'($urandom_range(1, NUM_PARTS - 1));
    // upper data bits of the policy write are don't-care, toggle them anyway
    write_reg(CFG_FIT_MODE, CFG_DAT_W'($urandom_range(0, 63)));
    write_reg(CFG_BLOCK_COUNT, cnt);
    if ($urandom_range(0, 5) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                CFG_DAT_W'($urandom_range(0, 63)));
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    int goal;
    for (int k = 0; k < NUM_PARTS; k++) begin
      shadow_size[k] = '0;
      shadow_used[k] = 1'b0;
      staged_size[k] = '0;
    end
    shadow_mode  = FIT_FIRST;
    shadow_count = BC_W'(NUM_PARTS);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the whole table first: sizes are undefined until loaded, and any
    // later block_count may scan every entry. Extremes at both ends.
    for (int k = 0; k < NUM_PARTS; k++) begin
      if (k == 0)                  push_cmd(REQ_LOAD, PIDX_W'(k), '0);
      else if (k == NUM_PARTS - 1) push_cmd(REQ_LOAD, PIDX_W'(k), '1);
      else                         push_cmd(REQ_LOAD, PIDX_W'(k),
                                            REQ_W'($urandom_range(1, 40)));
    end

    // directed, reset settings (first fit over all 32)
    push_cmd(REQ_ALLOC, '0, '0);           // zero request, lowest index
    push_cmd(REQ_ALLOC, '1, '1);           // only the largest partition fits
    push_cmd(REQ_ALLOC, '0, '1);           // now nothing fits
    push_cmd(REQ_LOAD, '1, 16'hAAAA);      // reload frees the used partition
    push_cmd(REQ_ALLOC, '0, 16'h5555);
    push_cmd(REQ_NOP, '1, '1);             // ignored type
    push_cmd(REQ_RESTORE, '0, '0);

    write_reg(CFG_FIT_MODE, CFG_DAT_W'(FIT_BEST));
    push_cmd(REQ_ALLOC, '0, 16'd20);
    push_cmd(REQ_ALLOC, '0, 16'd20);
    write_reg(CFG_FIT_MODE, CFG_DAT_W'(FIT_WORST));
    push_cmd(REQ_ALLOC, '0, 16'd1);
    push_cmd(REQ_ALLOC, '0, 16'd1);
    write_reg(CFG_FIT_MODE, CFG_DAT_W'(FIT_ALT));
    push_cmd(REQ_ALLOC, '0, 16'd1);

    write_reg(CFG_BLOCK_COUNT, '0);        // empty scan, never fits
    push_cmd(REQ_ALLOC, '0, '0);
    write_reg(CFG_BLOCK_COUNT, 6'd1);
    push_cmd(REQ_ALLOC, '0, '0);
    push_cmd(REQ_ALLOC, '0, '0);
    write_reg(CFG_BLOCK_COUNT, '1);        // saturates to the full table
    push_cmd(REQ_RESTORE, '1, '1);
    push_cmd(REQ_ALLOC, '0, 16'd30);
    write_reg(CFG_BLOCK_COUNT, BC_W'(NUM_PARTS + 1));
    push_cmd(REQ_ALLOC, '0, 16'd30);
    write_reg(CFG_SPARE_A, '1);            // spare slots are ignored
    write_reg(CFG_SPARE_B, '0);

    // random phases, each starting from an idle DUT with fresh settings
    goal = queued_count + RANDOM_WORDS;
    while (queued_count < goal - 80) begin
      pick_settings();
      narrow_sizes = $urandom_range(0, 2) == 0;
      case ($urandom_range(0, 3))
        0:       idle_odds = 0;
        1:       idle_odds = 2;
        default: idle_odds = $urandom_range(3, 8);
      endcase
      queue_phase($urandom_range(30, 100));
    end

    // closing stretch with no idling on either side
    pick_settings();
    wait_drained();
    quiet     = 1'b1;
    cmd_gap   = 0;
    rsp_stall = 0;
    queue_phase(60);

    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && due_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog: well beyond the slowest legal run (~2.2k words)
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
